>>> rtl/mtaf_pkg.sv
package mtaf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAX_WINDOW = 8;
    localparam int WIN_IDX_W  = 3;
    localparam int WLEN_W     = 4;
    localparam int ALEN_W     = 8;
    localparam int SUM_W      = 24;
    localparam int DIV_CNT_W  = 5;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [WLEN_W-1:0]   WLEN_RESET = 4'd3;
    localparam logic [ALEN_W-1:0]   ALEN_RESET = 8'd3;
    localparam logic [SAMPLE_W-1:0] NO_RESULT  = 16'hFFFF;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_LENGTH  = 1'b0;
    localparam logic REG_AVERAGE_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SORT,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_EMIT
    } t_back_state;

    // write side of a word queue
    typedef struct packed {
        logic                vld;
        logic [SAMPLE_W-1:0] data;
    } t_q_wr;

    // read side of a word queue
    typedef struct packed {
        logic                vld;
        logic [SAMPLE_W-1:0] data;
    } t_q_rd;

    function automatic logic [WLEN_W-1:0] eff_window(input logic [WLEN_W-1:0] wl);
        logic [WLEN_W-1:0] n;
        n = wl;
        if (wl == '0) begin
            n = WLEN_W'(1);
        end else if (wl > WLEN_W'(MAX_WINDOW)) begin
            n = WLEN_W'(MAX_WINDOW);
        end
        return n;
    endfunction

endpackage

>>> rtl/mtaf_fifo.sv
module mtaf_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mtaf_pkg::t_q_wr i_wr,
    output logic            o_full,
    output mtaf_pkg::t_q_rd o_rd,
    input  logic            i_pop
);

    logic [mtaf_pkg::SAMPLE_W-1:0] r_mem [2];
    logic                          r_wptr, n_wptr;
    logic                          r_rptr, n_rptr;
    logic [1:0]                    r_count, n_count;
    logic                          w_do_push;
    logic                          w_do_pop;

    assign o_full     = (r_count == 2'd2);
    assign o_rd.vld   = (r_count != 2'd0);
    assign o_rd.data  = r_mem[r_rptr];
    assign w_do_push  = i_wr.vld && !o_full;
    assign w_do_pop   = i_pop && o_rd.vld;

    always_comb begin
        n_wptr  = w_do_push ? ~r_wptr : r_wptr;
        n_rptr  = w_do_pop ? ~r_rptr : r_rptr;
        n_count = r_count + 2'(w_do_push) - 2'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_wr.data;
        end
    end

endmodule

>>> rtl/mtaf_front.sv
module mtaf_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [mtaf_pkg::WLEN_W-1:0]       i_window_length,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [mtaf_pkg::SAMPLE_W-1:0]     i_sample,
    output mtaf_pkg::t_q_wr                   o_med,
    input  logic                              i_med_full
);

    mtaf_pkg::t_front_state r_state, n_state;

    logic [mtaf_pkg::SAMPLE_W-1:0]  r_store [mtaf_pkg::MAX_WINDOW];
    logic [mtaf_pkg::SAMPLE_W-1:0]  n_store [mtaf_pkg::MAX_WINDOW];
    logic [mtaf_pkg::WIN_IDX_W-1:0] r_fill, n_fill;
    logic [mtaf_pkg::WIN_IDX_W-1:0] r_phase, n_phase;
    logic [mtaf_pkg::WLEN_W-1:0]    w_len;
    logic [mtaf_pkg::WLEN_W-1:0]    w_len_m1;
    logic [mtaf_pkg::WIN_IDX_W-1:0] w_last;
    logic [mtaf_pkg::WIN_IDX_W-1:0] w_mid;

    assign w_len    = mtaf_pkg::eff_window(i_window_length);
    assign w_len_m1 = w_len - mtaf_pkg::WLEN_W'(1);
    assign w_last   = w_len_m1[mtaf_pkg::WIN_IDX_W-1:0];
    assign w_mid    = w_len[mtaf_pkg::WLEN_W-1:1];
    assign o_full   = (r_state != mtaf_pkg::F_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtaf_pkg::F_IDLE;
            r_fill  <= '0;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_phase    = r_phase;
        n_store    = r_store;
        o_med.vld  = 1'b0;
        o_med.data = r_store[w_mid];
        case (r_state)
            mtaf_pkg::F_IDLE: begin
                if (i_push) begin
                    if ({1'b0, r_fill} < w_len_m1) begin
                        n_store[r_fill] = i_sample;
                        n_fill          = r_fill + mtaf_pkg::WIN_IDX_W'(1);
                    end else begin
                        // close the window: last slot, then sort
                        n_store[w_last] = i_sample;
                        n_fill          = '0;
                        n_phase         = '0;
                        n_state         = mtaf_pkg::F_SORT;
                    end
                end
            end
            mtaf_pkg::F_SORT: begin
                // odd-even transposition: disjoint pairs, one phase a cycle
                for (int k = 0; k < mtaf_pkg::MAX_WINDOW - 1; k++) begin
                    if (((k % 2) == int'(r_phase[0])) && ((k + 1) < int'(w_len))
                        && (r_store[k] > r_store[k+1])) begin
                        n_store[k]   = r_store[k+1];
                        n_store[k+1] = r_store[k];
                    end
                end
                if (r_phase == w_last) begin
                    n_state = mtaf_pkg::F_PUSH;
                end else begin
                    n_phase = r_phase + mtaf_pkg::WIN_IDX_W'(1);
                end
            end
            mtaf_pkg::F_PUSH: begin
                if (!i_med_full) begin
                    o_med.vld = 1'b1;
                    n_state   = mtaf_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = mtaf_pkg::F_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/mtaf_back.sv
module mtaf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mtaf_pkg::ALEN_W-1:0]   i_average_length,
    input  mtaf_pkg::t_q_rd               i_med,
    output logic                          o_med_pop,
    output mtaf_pkg::t_q_wr               o_out,
    input  logic                          i_out_full
);

    mtaf_pkg::t_back_state r_state, n_state;

    logic [mtaf_pkg::SUM_W-1:0]     r_sum, n_sum;
    logic [mtaf_pkg::ALEN_W-1:0]    r_tally, n_tally;
    logic [mtaf_pkg::SUM_W-1:0]     r_quo, n_quo;
    logic [mtaf_pkg::ALEN_W-1:0]    r_rem, n_rem;
    logic [mtaf_pkg::ALEN_W-1:0]    r_div, n_div;
    logic [mtaf_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [mtaf_pkg::SUM_W-1:0]     w_sum_add;
    logic [mtaf_pkg::ALEN_W-1:0]    w_tally_add;
    logic [mtaf_pkg::ALEN_W-1:0]    w_divisor;
    logic [mtaf_pkg::ALEN_W:0]      w_rem_shift;
    logic [mtaf_pkg::ALEN_W:0]      w_rem_sub;

    assign w_sum_add   = r_sum + mtaf_pkg::SUM_W'(i_med.data);
    assign w_tally_add = r_tally + mtaf_pkg::ALEN_W'(1);
    assign w_divisor   = (i_average_length == '0) ? mtaf_pkg::ALEN_W'(1) : i_average_length;
    assign w_rem_shift = {r_rem, r_quo[mtaf_pkg::SUM_W-1]};
    assign w_rem_sub   = w_rem_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtaf_pkg::B_IDLE;
            r_sum   <= '0;
            r_tally <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_tally <= n_tally;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    always_comb begin
        n_state    = r_state;
        n_sum      = r_sum;
        n_tally    = r_tally;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_div      = r_div;
        n_cnt      = r_cnt;
        o_med_pop  = 1'b0;
        o_out.vld  = 1'b0;
        o_out.data = r_quo[mtaf_pkg::SAMPLE_W-1:0];
        case (r_state)
            mtaf_pkg::B_IDLE: begin
                if (i_med.vld) begin
                    o_med_pop = 1'b1;
                    if (w_tally_add >= w_divisor) begin
                        // average complete: clear and start the divide
                        n_sum   = '0;
                        n_tally = '0;
                        n_quo   = w_sum_add;
                        n_rem   = '0;
                        n_div   = w_divisor;
                        n_cnt   = '0;
                        n_state = mtaf_pkg::B_DIV;
                    end else begin
                        n_sum   = w_sum_add;
                        n_tally = w_tally_add;
                    end
                end
            end
            mtaf_pkg::B_DIV: begin
                // restoring divide, one quotient bit a cycle
                if (!w_rem_sub[mtaf_pkg::ALEN_W]) begin
                    n_rem = w_rem_sub[mtaf_pkg::ALEN_W-1:0];
                    n_quo = {r_quo[mtaf_pkg::SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = w_rem_shift[mtaf_pkg::ALEN_W-1:0];
                    n_quo = {r_quo[mtaf_pkg::SUM_W-2:0], 1'b0};
                end
                if (r_cnt == mtaf_pkg::DIV_CNT_W'(mtaf_pkg::SUM_W - 1)) begin
                    n_state = mtaf_pkg::B_EMIT;
                end else begin
                    n_cnt = r_cnt + mtaf_pkg::DIV_CNT_W'(1);
                end
            end
            mtaf_pkg::B_EMIT: begin
                // drop the reserved all-ones average
                if (r_quo[mtaf_pkg::SAMPLE_W-1:0] == mtaf_pkg::NO_RESULT) begin
                    n_state = mtaf_pkg::B_IDLE;
                end else if (!i_out_full) begin
                    o_out.vld = 1'b1;
                    n_state   = mtaf_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = mtaf_pkg::B_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtaf_pkg::B_DIV) |-> (r_rem < r_div))
        else $error("divide remainder not below divisor");

    a_no_reserved_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.vld |-> (o_out.data != mtaf_pkg::NO_RESULT))
        else $error("reserved average pushed to output queue");

    a_emit_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == mtaf_pkg::B_EMIT) |->
            ($past(r_state) == mtaf_pkg::B_DIV) && ($past(r_cnt) ==
            mtaf_pkg::DIV_CNT_W'(mtaf_pkg::SUM_W - 1)))
        else $error("emit entered before divide finished");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_med_pop |-> (r_state == mtaf_pkg::B_IDLE) && i_med.vld)
        else $error("median popped outside idle");
`endif

endmodule

>>> rtl/median_then_average_filter_top.sv
// A sample that closes a window of n entries yields its average, if any, on the
//   output ports after n sort phases, the median push, the pop into the back end,
//   the serial divide and the output push.
// Samples are taken one per cycle while a window fills; after the closing sample
//   the front is full until its median is pushed, and the back pops none while it divides.
// Reset: synchronous, active low; clears fill, sum, tally, queues, and sets both
//   lengths to 3. Window storage is not cleared.
module median_then_average_filter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mtaf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mtaf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mtaf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic [mtaf_pkg::SAMPLE_W-1:0]       i_sample,
    output logic                                empty,
    input  logic                                pop,
    output logic [mtaf_pkg::SAMPLE_W-1:0]       o_filtered_value
);

    logic [mtaf_pkg::WLEN_W-1:0] r_window_length;
    logic [mtaf_pkg::ALEN_W-1:0] r_average_length;
    logic                        w_cfg_wr;

    mtaf_pkg::t_q_wr w_med_wr;
    mtaf_pkg::t_q_rd w_med_rd;
    logic            w_med_full;
    logic            w_med_pop;
    mtaf_pkg::t_q_wr w_out_wr;
    mtaf_pkg::t_q_rd w_out_rd;
    logic            w_out_full;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length  <= mtaf_pkg::WLEN_RESET;
            r_average_length <= mtaf_pkg::ALEN_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                mtaf_pkg::REG_WINDOW_LENGTH: begin
                    r_window_length <= pwdata[mtaf_pkg::WLEN_W-1:0];
                end
                mtaf_pkg::REG_AVERAGE_LENGTH: begin
                    r_average_length <= pwdata[mtaf_pkg::ALEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mtaf_pkg::REG_WINDOW_LENGTH:  prdata = mtaf_pkg::APB_DATA_W'(r_window_length);
            mtaf_pkg::REG_AVERAGE_LENGTH: prdata = mtaf_pkg::APB_DATA_W'(r_average_length);
            default:                      prdata = '0;
        endcase
    end

    mtaf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_window_length (r_window_length),
        .i_push          (push),
        .o_full          (full),
        .i_sample        (i_sample),
        .o_med           (w_med_wr),
        .i_med_full      (w_med_full)
    );

    mtaf_fifo u_med_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_med_wr),
        .o_full  (w_med_full),
        .o_rd    (w_med_rd),
        .i_pop   (w_med_pop)
    );

    mtaf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_average_length (r_average_length),
        .i_med            (w_med_rd),
        .o_med_pop        (w_med_pop),
        .o_out            (w_out_wr),
        .i_out_full       (w_out_full)
    );

    mtaf_fifo u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_out_wr),
        .o_full  (w_out_full),
        .o_rd    (w_out_rd),
        .i_pop   (pop)
    );

    assign empty            = !w_out_rd.vld;
    assign o_filtered_value = w_out_rd.data;

endmodule

>>> dv/median_then_average_filter_top_test.sv
`timescale 1ns / 100ps

module median_then_average_filter_top_test;

    localparam int unsigned SETTLE_CYCLES = 120;
    localparam int unsigned HOLD_CYCLES   = 1500;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          DIR_ROWS      = 32;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_VALUE,
        CHK_NONE
    } t_avg_check;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic                          reg_sel;
        logic [mtaf_pkg::SAMPLE_W-1:0] data;
        t_avg_check                    chk;
        logic [mtaf_pkg::SAMPLE_W-1:0] want;
    } t_stim_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mtaf_pkg::APB_ADDR_W-1:0] paddr;
    logic [mtaf_pkg::APB_DATA_W-1:0] pwdata;
    logic [mtaf_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            push;
    logic                            full;
    logic [mtaf_pkg::SAMPLE_W-1:0]   i_sample;
    logic                            empty;
    logic                            pop;
    logic [mtaf_pkg::SAMPLE_W-1:0]   o_filtered_value;

    // predicted filter state
    logic [mtaf_pkg::SAMPLE_W-1:0] win_buf [mtaf_pkg::MAX_WINDOW];
    int unsigned                   fill_cnt;
    logic [mtaf_pkg::SUM_W-1:0]    median_acc;
    logic [mtaf_pkg::ALEN_W-1:0]   median_cnt;
    logic [mtaf_pkg::WLEN_W-1:0]   wlen_cfg;
    logic [mtaf_pkg::ALEN_W-1:0]   alen_cfg;

    logic [mtaf_pkg::SAMPLE_W-1:0] avg_expect_q [$];
    int unsigned                   mismatch_cnt = 0;
    int unsigned                   results_seen = 0;
    int unsigned                   cycle_cnt = 0;
    bit                            hold_req = 1'b0;

    t_stim_row dir_rows [DIR_ROWS] = '{
        // reset lengths: three windows of three
        '{ROW_SAMPLE, 1'b0, 16'd5,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd1,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd9,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd0,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd0,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd0,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'hFFFF,   CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'hFFFF,   CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd10,     CHK_VALUE, 16'd21846},
        // zero lengths act as one
        '{ROW_WRITE,  mtaf_pkg::REG_WINDOW_LENGTH,  16'd0,  CHK_NONE, 16'd0},
        '{ROW_WRITE,  mtaf_pkg::REG_AVERAGE_LENGTH, 16'd0,  CHK_NONE, 16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd0,      CHK_VALUE, 16'd0},
        '{ROW_SAMPLE, 1'b0, 16'hFFFF,   CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'hFFFE,   CHK_VALUE, 16'hFFFE},
        // oversized window saturates to eight
        '{ROW_WRITE,  mtaf_pkg::REG_WINDOW_LENGTH,  16'd15, CHK_NONE, 16'd0},
        '{ROW_WRITE,  mtaf_pkg::REG_AVERAGE_LENGTH, 16'd4,  CHK_NONE, 16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd8,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd7,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd6,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd5,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd4,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd3,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd2,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd1,      CHK_NONE,  16'd0},
        // shorten the window while three samples are held
        '{ROW_SAMPLE, 1'b0, 16'd100,    CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd200,    CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd300,    CHK_NONE,  16'd0},
        '{ROW_WRITE,  mtaf_pkg::REG_WINDOW_LENGTH,  16'd2,  CHK_NONE, 16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd50,     CHK_MODEL, 16'd0},
        // drop the average length below the tally
        '{ROW_WRITE,  mtaf_pkg::REG_AVERAGE_LENGTH, 16'd1,  CHK_NONE, 16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd7,      CHK_NONE,  16'd0},
        '{ROW_SAMPLE, 1'b0, 16'd9,      CHK_MODEL, 16'd0}
    };

    median_then_average_filter_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .push             (push),
        .full             (full),
        .i_sample         (i_sample),
        .empty            (empty),
        .pop              (pop),
        .o_filtered_value (o_filtered_value)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got 0x%0h want 0x%0h (cycle %0d)", what, got, want, cycle_cnt);
        mismatch_cnt++;
    endtask

    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        if (steady || cycle_cnt[10:9] == 2'b11) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 16);
        end
        return $urandom_range(40, 120);
    endfunction

    function automatic logic [mtaf_pkg::SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return mtaf_pkg::SAMPLE_W'($urandom_range(0, 15));
            end
            3: begin
                return 16'hFFFF - mtaf_pkg::SAMPLE_W'($urandom_range(0, 15));
            end
            default: begin
                return mtaf_pkg::SAMPLE_W'($urandom);
            end
        endcase
    endfunction

    // Advance the filter by one sample; return 1 when an average word comes out.
    function automatic bit median_avg_predict(input logic [mtaf_pkg::SAMPLE_W-1:0] smp,
                                              output logic [mtaf_pkg::SAMPLE_W-1:0] avg);
        int unsigned                   n;
        int unsigned                   divisor;
        int unsigned                   p;
        int unsigned                   k;
        logic [mtaf_pkg::SAMPLE_W-1:0] tmp;
        logic [mtaf_pkg::SUM_W-1:0]    quot;
        avg = '0;
        n = (wlen_cfg == '0) ? 1 : ((wlen_cfg > mtaf_pkg::MAX_WINDOW) ?
            mtaf_pkg::MAX_WINDOW : wlen_cfg);
        if (fill_cnt < n - 1) begin
            win_buf[fill_cnt] = smp;
            fill_cnt++;
            return 1'b0;
        end
        // a shortened window closes here, at its last slot
        win_buf[n - 1] = smp;
        for (p = 0; p + 1 < n; p++) begin
            for (k = 0; k + 1 < n - p; k++) begin
                if (win_buf[k] > win_buf[k + 1]) begin
                    tmp = win_buf[k];
                    win_buf[k] = win_buf[k + 1];
                    win_buf[k + 1] = tmp;
                end
            end
        end
        fill_cnt = 0;
        median_acc = median_acc + mtaf_pkg::SUM_W'(win_buf[n / 2]);
        median_cnt = median_cnt + 1'b1;
        divisor = (alen_cfg == '0) ? 1 : alen_cfg;
        if (median_cnt < divisor) begin
            return 1'b0;
        end
        quot = median_acc / mtaf_pkg::SUM_W'(divisor);
        median_acc = '0;
        median_cnt = '0;
        avg = quot[mtaf_pkg::SAMPLE_W-1:0];
        return avg != mtaf_pkg::NO_RESULT;
    endfunction

    // Drop push, wait out every expected word, then let the back end go quiet.
    task automatic settle_block();
        push <= 1'b0;
        while (avg_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic reg_sel,
                             input logic [mtaf_pkg::APB_DATA_W-1:0] val);
        logic [mtaf_pkg::APB_DATA_W-1:0] rd_val;
        settle_block();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == mtaf_pkg::REG_WINDOW_LENGTH) begin
            wlen_cfg = val[mtaf_pkg::WLEN_W-1:0];
        end else begin
            alen_cfg = val[mtaf_pkg::ALEN_W-1:0];
        end
        // read it back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd_val = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd_val != val) begin
            report_mismatch("register readback", rd_val, val);
        end
    endtask

    task automatic send_sample(input logic [mtaf_pkg::SAMPLE_W-1:0] smp,
                               input t_avg_check chk,
                               input logic [mtaf_pkg::SAMPLE_W-1:0] want, input bit steady);
        logic [mtaf_pkg::SAMPLE_W-1:0] avg;
        bit                            has_avg;
        int unsigned                   gap;
        push     <= 1'b1;
        i_sample <= smp;
        do @(posedge i_clk); while (full);
        has_avg = median_avg_predict(smp, avg);
        case (chk)
            CHK_MODEL: begin
                if (has_avg) begin
                    avg_expect_q.push_back(avg);
                end
            end
            CHK_VALUE: begin
                avg_expect_q.push_back(want);
            end
            default: begin
            end
        endcase
        gap = pick_gap(steady);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side
    initial begin
        int unsigned                   stall_left;
        logic [mtaf_pkg::SAMPLE_W-1:0] want;
        stall_left = 0;
        pop <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                results_seen++;
                if (avg_expect_q.size() == 0) begin
                    report_mismatch("filtered_value with none waiting",
                                    32'(o_filtered_value), 32'(0));
                end else begin
                    want = avg_expect_q.pop_front();
                    if (o_filtered_value != want) begin
                        report_mismatch("filtered_value", 32'(o_filtered_value), 32'(want));
                    end
                end
            end
            if (hold_req) begin
                // hold off long enough for the block to back up into full
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                stall_left = pick_gap(1'b0);
            end
        end
    end

    // sample side
    initial begin
        int unsigned                 rnd_items;
        int unsigned                 phase_no;
        int unsigned                 cnt;
        logic [mtaf_pkg::WLEN_W-1:0] wl;
        logic [mtaf_pkg::ALEN_W-1:0] al;
        bit                          squeeze;
        i_rst_n  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        push     <= 1'b0;
        i_sample <= '0;
        for (int i = 0; i < mtaf_pkg::MAX_WINDOW; i++) begin
            win_buf[i] = '0;
        end
        fill_cnt   = 0;
        median_acc = '0;
        median_cnt = '0;
        wlen_cfg   = mtaf_pkg::WLEN_RESET;
        alen_cfg   = mtaf_pkg::ALEN_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                cfg_write(dir_rows[i].reg_sel, mtaf_pkg::APB_DATA_W'(dir_rows[i].data));
            end else begin
                send_sample(dir_rows[i].data, dir_rows[i].chk, dir_rows[i].want, 1'b0);
            end
        end

        rnd_items = 0;
        phase_no  = 0;
        while (rnd_items < 750) begin
            squeeze = 1'b0;
            if (phase_no == 0) begin
                // longest average, a few medians left over for the next phase
                wl  = 4'd1;
                al  = 8'd255;
                cnt = 258;
            end else if (phase_no == 2) begin
                wl      = 4'd1;
                al      = 8'd1;
                cnt     = 80;
                squeeze = 1'b1;
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    wl = $urandom_range(0, 1) ? 4'd0 :
                        mtaf_pkg::WLEN_W'($urandom_range(9, 15));
                end else begin
                    wl = mtaf_pkg::WLEN_W'($urandom_range(1, mtaf_pkg::MAX_WINDOW));
                end
                if ($urandom_range(0, 9) == 0) begin
                    al = $urandom_range(0, 1) ? 8'd0 :
                        mtaf_pkg::ALEN_W'($urandom_range(9, 40));
                end else begin
                    al = mtaf_pkg::ALEN_W'($urandom_range(1, 5));
                end
                cnt = $urandom_range(4, 60);
            end
            cfg_write(mtaf_pkg::REG_WINDOW_LENGTH, mtaf_pkg::APB_DATA_W'(wl));
            cfg_write(mtaf_pkg::REG_AVERAGE_LENGTH, mtaf_pkg::APB_DATA_W'(al));
            if (squeeze) begin
                hold_req = 1'b1;
            end
            repeat (cnt) begin
                send_sample(draw_sample(), CHK_MODEL, '0, squeeze);
            end
            rnd_items += cnt;
            phase_no++;
        end

        settle_block();
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
